FILE: rtl/core/afhd_pkg.sv
package afhd_pkg;

    localparam int HEADER_LEN = 12;
    localparam int HDR_BITS   = HEADER_LEN * 8;

    // Field positions inside the header shift register; the first byte ends up on top.
    localparam int MAGIC_LSB = HDR_BITS - 32;
    localparam int SEQ_LSB   = HDR_BITS - 64;
    localparam int LEN_LSB   = HDR_BITS - 96;

    localparam logic [16:0] MAX_PAYLOAD_RST = 17'h10000;
    localparam logic [31:0] MAGIC_WORD_RST  = 32'h5241_5631;

    typedef enum logic {
        REG_MAX_PAYLOAD = 1'b0,
        REG_MAGIC_WORD  = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_ZERO_SEQ  = 3'd3,
        ST_MISMATCH  = 3'd4,
        ST_TOO_LARGE = 3'd5
    } t_status;

    // What the front end hands to the back end for one accepted item.
    typedef struct packed {
        logic        has_payload;
        logic [7:0]  payload_byte;
        logic        has_status;
        t_status     status_code;
        logic [31:0] sequence_number;
        logic [31:0] payload_length;
    } t_op;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

endpackage

FILE: rtl/core/audio_frame_header_deframer_core.sv
// A result reaches the output ports through its queue entry and then the result register in
// the back end; it waits in the queue while the result side does not pop.
// Throughput: one byte per cycle unless the queue is full; one result per cycle when popped,
// so a frame's last byte that also carries payload gives two results (payload, then status).
// The front end and the result stage are parted by a QUEUE_DEPTH-entry queue. Reset is
// synchronous and active low: it empties the queue, clears the counter, reloads the registers.
module audio_frame_header_deframer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_byte_value,
    input  logic        i_frame_end,
    input  logic        i_pop,
    output logic        o_empty,
    output logic        o_is_status,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status_code,
    output logic [31:0] o_sequence_number,
    output logic [31:0] o_payload_length,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import afhd_pkg::*;

    t_op     w_enq_op;
    t_op     w_head_op;
    t_q_stat w_q_stat;
    logic    w_enq;
    logic    w_q_pop;

    afhd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_byte_value (i_byte_value),
        .i_frame_end  (i_frame_end),
        .i_q_full     (w_q_stat.full),
        .o_full       (o_full),
        .o_enq        (w_enq),
        .o_op         (w_enq_op),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    afhd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_enq),
        .i_data  (w_enq_op),
        .i_pop   (w_q_pop),
        .o_data  (w_head_op),
        .o_stat  (w_q_stat)
    );

    afhd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (w_head_op),
        .i_q_stat          (w_q_stat),
        .o_q_pop           (w_q_pop),
        .i_pop             (i_pop),
        .o_empty           (o_empty),
        .o_is_status       (o_is_status),
        .o_payload_byte    (o_payload_byte),
        .o_status_code     (o_status_code),
        .o_sequence_number (o_sequence_number),
        .o_payload_length  (o_payload_length),
        .o_last            (o_last)
    );

    a_enq_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_enq |-> !w_q_stat.full)
        else $error("item queued while the queue is full");

    a_status_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_is_status) |-> (o_status_code <= 3'(ST_TOO_LARGE)))
        else $error("status code out of range");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_is_status) |->
            (o_status_code == 3'(ST_OK) && o_sequence_number == 32'd0 &&
             o_payload_length == 32'd0 && !o_last))
        else $error("payload result carries status fields");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result shown straight after reset");

endmodule

FILE: rtl/core/afhd_front.sv
module afhd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [7:0]     i_byte_value,
    input  logic           i_frame_end,
    input  logic           i_q_full,
    output logic           o_full,
    output logic           o_enq,
    output afhd_pkg::t_op  o_op,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import afhd_pkg::*;

    logic [16:0]         r_max_payload;
    logic [31:0]         r_magic_word;
    logic [31:0]         r_count;
    logic [31:0]         r_pay;
    logic [HDR_BITS-1:0] r_hdr;

    logic [HDR_BITS-1:0] n_hdr;
    logic [31:0]         n_count;
    logic [31:0]         w_recv;
    logic                w_hdr_byte;
    logic                w_sat;
    logic                w_accept;
    logic                w_short;
    logic [31:0]         w_magic;
    logic [31:0]         w_seq;
    logic [31:0]         w_len;
    t_status             w_code;

    assign o_cfg_ready = 1'b1;
    assign o_full      = i_q_full;
    assign w_accept    = i_push && !i_q_full;

    always_comb begin
        w_hdr_byte = r_count < 32'(HEADER_LEN);
        w_sat      = r_count == 32'hFFFF_FFFF;
        n_hdr      = w_hdr_byte ? {r_hdr[HDR_BITS-9:0], i_byte_value} : r_hdr;
        n_count    = w_sat ? r_count : r_count + 32'd1;
        // Payload bytes seen so far, including this one; stops with the saturated counter.
        w_recv     = r_pay + 32'((!w_hdr_byte) && (!w_sat));
        // The frame is short if the counter stays below the header length after this byte.
        w_short    = r_count < 32'(HEADER_LEN - 1);
        w_magic    = n_hdr[MAGIC_LSB +: 32];
        w_seq      = n_hdr[SEQ_LSB +: 32];
        w_len      = n_hdr[LEN_LSB +: 32];

        if (w_short) begin
            w_code = ST_SHORT;
        end else if (w_magic != r_magic_word) begin
            w_code = ST_MAGIC;
        end else if (w_seq == 32'd0) begin
            w_code = ST_ZERO_SEQ;
        end else if ((w_len == 32'd0) || (w_len != w_recv)) begin
            w_code = ST_MISMATCH;
        end else if (w_len > {15'd0, r_max_payload}) begin
            w_code = ST_TOO_LARGE;
        end else begin
            w_code = ST_OK;
        end

        o_op.has_payload     = !w_hdr_byte;
        o_op.payload_byte    = i_byte_value;
        o_op.has_status      = i_frame_end;
        o_op.status_code     = w_code;
        o_op.sequence_number = w_short ? 32'd0 : w_seq;
        o_op.payload_length  = w_short ? 32'd0 : w_len;
        o_enq                = w_accept && ((!w_hdr_byte) || i_frame_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_magic_word  <= MAGIC_WORD_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[16:0];
                REG_MAGIC_WORD:  r_magic_word  <= i_cfg_data;
                default:         r_magic_word  <= r_magic_word;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 32'd0;
            r_pay   <= 32'd0;
        end else if (w_accept) begin
            if (i_frame_end) begin
                r_count <= 32'd0;
                r_pay   <= 32'd0;
            end else begin
                r_count <= n_count;
                r_pay   <= w_recv;
            end
        end
    end

    // The header store has no reset; it is only read once a full header has arrived.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hdr <= n_hdr;
        end
    end

endmodule

FILE: rtl/core/afhd_queue.sv
module afhd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  afhd_pkg::t_op    i_data,
    input  logic             i_pop,
    output afhd_pkg::t_op    o_data,
    output afhd_pkg::t_q_stat o_stat
);
    import afhd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_LVL = CW'(DEPTH);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_level;

    logic w_wr;
    logic w_rd;

    assign o_stat.valid = r_level != '0;
    assign o_stat.full  = r_level == FULL_LVL;
    assign o_data       = r_mem[r_rd_ptr];
    assign w_wr         = i_push && !o_stat.full;
    assign w_rd         = i_pop && o_stat.valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_wr && !w_rd) begin
                r_level <= r_level + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_level <= r_level - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/afhd_back.sv
module afhd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  afhd_pkg::t_op     i_op,
    input  afhd_pkg::t_q_stat i_q_stat,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_is_status,
    output logic [7:0]        o_payload_byte,
    output logic [2:0]        o_status_code,
    output logic [31:0]       o_sequence_number,
    output logic [31:0]       o_payload_length,
    output logic              o_last
);
    import afhd_pkg::*;

    t_op  r_op;
    logic r_valid;
    logic r_pay_done;

    logic w_show_pay;
    logic w_pop;
    logic w_finish;

    assign w_show_pay = r_op.has_payload && !r_pay_done;
    assign w_pop      = i_pop && r_valid;
    // The held item is finished unless a status result still follows its payload result.
    assign w_finish   = w_pop && !(w_show_pay && r_op.has_status);
    assign o_q_pop    = (!r_valid || w_finish) && i_q_stat.valid;

    assign o_empty           = !r_valid;
    assign o_is_status       = !w_show_pay;
    assign o_payload_byte    = w_show_pay ? r_op.payload_byte : 8'd0;
    assign o_status_code     = w_show_pay ? 3'(ST_OK) : 3'(r_op.status_code);
    assign o_sequence_number = w_show_pay ? 32'd0 : r_op.sequence_number;
    assign o_payload_length  = w_show_pay ? 32'd0 : r_op.payload_length;
    assign o_last            = !w_show_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pay_done <= 1'b0;
        end else if (o_q_pop) begin
            r_valid    <= 1'b1;
            r_pay_done <= 1'b0;
        end else if (w_finish) begin
            r_valid    <= 1'b0;
            r_pay_done <= 1'b0;
        end else if (w_pop) begin
            r_pay_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op <= i_op;
        end
    end

endmodule

FILE: tb/tb_audio_frame_header_deframer_core.sv
`timescale 1ns / 100ps

module tb_audio_frame_header_deframer_core;
    import afhd_pkg::*;

    typedef struct {
        logic [7:0] value;
        logic       frame_end;
    } t_link_byte;

    typedef struct {
        logic        is_status;
        logic [7:0]  pbyte;
        logic [2:0]  code;
        logic [31:0] seq;
        logic [31:0] len;
        logic        last;
    } t_deframed;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_push       = 1'b0;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_frame_end  = 1'b0;
    logic        i_pop        = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    t_reg_idx    i_cfg_index  = REG_MAX_PAYLOAD;
    logic [31:0] i_cfg_data   = 32'h0;

    logic        o_full;
    logic        o_empty;
    logic        o_is_status;
    logic [7:0]  o_payload_byte;
    logic [2:0]  o_status_code;
    logic [31:0] o_sequence_number;
    logic [31:0] o_payload_length;
    logic        o_last;
    logic        o_cfg_ready;

    audio_frame_header_deframer_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_byte_value      (i_byte_value),
        .i_frame_end       (i_frame_end),
        .i_pop             (i_pop),
        .o_empty           (o_empty),
        .o_is_status       (o_is_status),
        .o_payload_byte    (o_payload_byte),
        .o_status_code     (o_status_code),
        .o_sequence_number (o_sequence_number),
        .o_payload_length  (o_payload_length),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Bytes waiting to go onto the link, and the results they are known to cause.
    t_link_byte link_q[$];
    t_deframed  deframed_q[$];
    t_link_byte tx_next;

    // Our own copy of the deframer state and its registers.
    logic [7:0]  hdr_store [HEADER_LEN];
    logic [31:0] rx_count  = 32'h0;
    logic [16:0] lim_max   = MAX_PAYLOAD_RST;
    logic [31:0] lim_magic = MAGIC_WORD_RST;

    int   cyc         = 0;
    int   bad_results = 0;
    logic rx_hold     = 1'b0;
    logic stall_go    = 1'b0;
    logic calm;

    // A quarter of the time, neither side idles at random.
    assign calm = (cyc % 1024) >= 768;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    function automatic void deframe_byte(input logic [7:0] b, input logic fe);
        t_deframed   r;
        logic [31:0] seq;
        logic [31:0] len;
        logic [31:0] got;
        logic [2:0]  code;
        if (rx_count < HEADER_LEN) begin
            hdr_store[rx_count] = b;
        end else begin
            r.is_status = 1'b0;
            r.pbyte     = b;
            r.code      = ST_OK;
            r.seq       = 32'h0;
            r.len       = 32'h0;
            r.last      = 1'b0;
            deframed_q  = {deframed_q, r};
        end
        if (rx_count != 32'hFFFF_FFFF) begin
            rx_count = rx_count + 1;
        end
        if (fe) begin
            seq = 32'h0;
            len = 32'h0;
            if (rx_count < HEADER_LEN) begin
                code = ST_SHORT;
            end else begin
                got = rx_count - HEADER_LEN;
                seq = {hdr_store[4], hdr_store[5], hdr_store[6], hdr_store[7]};
                len = {hdr_store[8], hdr_store[9], hdr_store[10], hdr_store[11]};
                if ({hdr_store[0], hdr_store[1], hdr_store[2], hdr_store[3]} != lim_magic) begin
                    code = ST_MAGIC;
                end else if (seq == 32'h0) begin
                    code = ST_ZERO_SEQ;
                end else if (len == 32'h0 || len != got) begin
                    code = ST_MISMATCH;
                end else if (len > {15'h0, lim_max}) begin
                    code = ST_TOO_LARGE;
                end else begin
                    code = ST_OK;
                end
            end
            r.is_status = 1'b1;
            r.pbyte     = 8'h00;
            r.code      = code;
            r.seq       = seq;
            r.len       = len;
            r.last      = 1'b1;
            deframed_q  = {deframed_q, r};
            rx_count = 32'h0;
        end
    endfunction

    // Sender: once the offered byte has gone, takes the next one from link_q or idles at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                deframe_byte(i_byte_value, i_frame_end);
            end
            if (!i_push || !o_full) begin
                if (link_q.size() > 0 && (calm || $urandom_range(0, 99) >= 7)) begin
                    tx_next = link_q.pop_front();
                    i_push       <= 1'b1;
                    i_byte_value <= tx_next.value;
                    i_frame_end  <= tx_next.frame_end;
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    task automatic check_result();
        t_deframed e;
        if (deframed_q.size() == 0) begin
            bad_results++;
            if (bad_results <= 10) begin
                $display("unexpected result: st=%0d byte=%02h code=%0d seq=%08h len=%08h last=%0d",
                         o_is_status, o_payload_byte, o_status_code, o_sequence_number,
                         o_payload_length, o_last);
            end
        end else begin
            e = deframed_q.pop_front();
            if (o_is_status !== e.is_status || o_payload_byte !== e.pbyte ||
                o_status_code !== e.code || o_sequence_number !== e.seq ||
                o_payload_length !== e.len || o_last !== e.last) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("mismatch: exp st=%0d byte=%02h code=%0d seq=%08h len=%08h last=%0d",
                             e.is_status, e.pbyte, e.code, e.seq, e.len, e.last);
                    $display("          got st=%0d byte=%02h code=%0d seq=%08h len=%08h last=%0d",
                             o_is_status, o_payload_byte, o_status_code, o_sequence_number,
                             o_payload_length, o_last);
                end
            end
        end
    endtask

    // Receiver: pops at random and checks every result taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                check_result();
            end
            i_pop <= !rx_hold && (calm || $urandom_range(0, 99) >= 7);
        end
    end

    // Long hold-off on the result side so that the block backs up and raises full.
    initial begin
        while (!stall_go) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_MAX_PAYLOAD) begin
            lim_max = val[16:0];
        end else begin
            lim_magic = val;
        end
    endtask

    // Queues the first total bytes of a frame built from the given header fields.
    task automatic queue_frame(input logic [31:0] magic, input logic [31:0] seq,
                               input logic [31:0] len, input int total);
        logic [95:0] hdr_bits;
        t_link_byte  lb;
        hdr_bits = {magic, seq, len};
        for (int i = 0; i < total; i++) begin
            lb.value     = (i < HEADER_LEN) ? hdr_bits[95 - 8 * i -: 8] : 8'($urandom);
            lb.frame_end = (i == total - 1);
            link_q       = {link_q, lb};
        end
    endtask

    // Mostly well-formed frames with random content; the rest are short or carry broken header fields.
    task automatic queue_random_frames(input int budget);
        int          sent;
        int          kind;
        int          plen;
        int          total;
        logic [31:0] magic;
        logic [31:0] seq;
        logic [31:0] len;
        sent = 0;
        while (sent < budget) begin
            kind  = $urandom_range(0, 99);
            magic = lim_magic;
            seq   = $urandom;
            if (seq == 32'h0) begin
                seq = 32'h1;
            end
            plen  = $urandom_range(1, 20);
            len   = plen;
            total = HEADER_LEN + plen;
            if (kind >= 95) begin
                magic = $urandom;
                seq   = $urandom;
                len   = $urandom;
            end else if (kind >= 89) begin
                case ($urandom_range(0, 2))
                    0: len = 32'h0;
                    1: len = plen + 1;
                    default: len = $urandom;
                endcase
            end else if (kind >= 85) begin
                seq = 32'h0;
            end else if (kind >= 80) begin
                magic = magic ^ (32'h1 << $urandom_range(0, 31));
            end else if (kind >= 75) begin
                total = $urandom_range(1, HEADER_LEN - 1);
            end
            queue_frame(magic, seq, len, total);
            sent += total;
        end
    endtask

    // Waits until the sender has nothing left and every expected result has come.
    task automatic wait_drained();
        while (link_q.size() != 0 || i_push || deframed_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limits: at least one frame per status code reachable at the default limit.
        queue_frame(lim_magic, 32'h1, 32'h1, 1);
        queue_frame(lim_magic, 32'h1, 32'h1, HEADER_LEN - 1);
        queue_frame(lim_magic, 32'hFFFF_FFFF, 32'h1, HEADER_LEN + 1);
        queue_frame(~lim_magic, 32'h5, 32'h1, HEADER_LEN + 1);
        queue_frame(lim_magic, 32'h0, 32'h1, HEADER_LEN + 1);
        queue_frame(lim_magic, 32'h7, 32'h0, HEADER_LEN);
        queue_frame(lim_magic, 32'h8, 32'hFFFF_FFFF, HEADER_LEN + 1);
        queue_frame(lim_magic, 32'h9, 32'h2, HEADER_LEN + 3);
        queue_random_frames(100);
        wait_drained();

        // A limit of one byte and an all-zero magic.
        write_reg(REG_MAX_PAYLOAD, 32'd1);
        write_reg(REG_MAGIC_WORD, 32'h0);
        queue_frame(lim_magic, 32'h1, 32'h1, HEADER_LEN + 1);
        queue_frame(lim_magic, 32'h2, 32'h2, HEADER_LEN + 2);
        queue_random_frames(100);
        stall_go <= 1'b1;
        wait_drained();

        // The reset limit of 65536 and an all-ones magic.
        write_reg(REG_MAX_PAYLOAD, 32'd65536);
        write_reg(REG_MAGIC_WORD, 32'hFFFF_FFFF);
        queue_random_frames(100);
        wait_drained();

        // A limit inside the payload sizes used, so both sides of it are hit.
        write_reg(REG_MAX_PAYLOAD, $urandom_range(4, 16));
        write_reg(REG_MAGIC_WORD, $urandom);
        queue_random_frames(110);
        wait_drained();

        if (bad_results == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/afhd_pkg.sv
rtl/core/afhd_front.sv
rtl/core/afhd_queue.sv
rtl/core/afhd_back.sv
rtl/core/audio_frame_header_deframer_core.sv
tb/tb_audio_frame_header_deframer_core.sv
